// ===== hw/rtl/pts_pkg.sv =====
// Shared constants, codes, types and helpers of the polynomial term store engine.
package pts_pkg;

  localparam int MAX_DEGREE = 63;
  localparam int NUM_SLOTS  = 4;

  localparam int TERMS     = MAX_DEGREE + 1;
  localparam int EXP_W     = $clog2(TERMS);
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int ADDR_W    = SLOT_W + EXP_W;
  localparam int RAM_DEPTH = 2 ** ADDR_W;
  localparam int CNT_W     = $clog2(TERMS + 1);

  localparam logic [2:0] K_ADD_TERM  = 3'd0;
  localparam logic [2:0] K_DEL_TERM  = 3'd1;
  localparam logic [2:0] K_EVALUATE  = 3'd2;
  localparam logic [2:0] K_ADD_SLOTS = 3'd3;
  localparam logic [2:0] K_MUL_SLOTS = 3'd4;
  localparam logic [2:0] K_CLEAR     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ABSENT   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_ALIAS    = 3'd4;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic             fin;
    logic [EXP_W-1:0] tag;
  } mac_in_t;

  typedef struct packed {
    logic             vld;
    logic             fin;
    logic [EXP_W-1:0] tag;
    logic [31:0]      sum;
  } mac_out_t;

  // Slot fields are below twice NUM_SLOTS, so one compare and subtract reduces them.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] f);
    if (int'(f) >= NUM_SLOTS) begin
      return SLOT_W'(int'(f) - NUM_SLOTS);
    end
    return SLOT_W'(f);
  endfunction

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [SLOT_W-1:0] s,
                                                input logic [EXP_W-1:0] e);
    return {s, e};
  endfunction

endpackage

// ===== hw/rtl/pts_if.sv =====
// Handshake channel interfaces for the request and result items.
interface pts_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [1:0]         slot;
  logic [1:0]         second_slot;
  logic [1:0]         dest_slot;
  logic signed [31:0] coef;
  logic [5:0]         exponent;
  logic signed [31:0] x_value;

  modport source (output valid, kind, slot, second_slot, dest_slot, coef, exponent, x_value,
                  input ready);
  modport sink (input valid, kind, slot, second_slot, dest_slot, coef, exponent, x_value,
                output ready);
endinterface

interface pts_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] value;
  logic [6:0]         term_count;

  modport source (output valid, status, value, term_count, input ready);
  modport sink (input valid, status, value, term_count, output ready);
endinterface

// ===== hw/rtl/pts_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
module pts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ===== hw/rtl/pts_mac.sv =====
// Multiply-accumulate pipeline: registered product, then a running sum closed by a last flag.
module pts_mac (
  input  logic              clk,
  input  logic              rst,
  input  pts_pkg::mac_in_t  op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output pts_pkg::mac_out_t res
);
  import pts_pkg::*;

  mac_in_t     p_op;
  logic [31:0] prod;
  logic [31:0] acc;
  logic [31:0] sum;

  assign sum = acc + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_op.vld <= 1'b0;
      acc      <= '0;
    end else begin
      p_op.vld <= op.vld;
      if (p_op.vld) begin
        acc <= p_op.last ? 32'd0 : sum;
      end
    end
    p_op.last <= op.last;
    p_op.fin  <= op.fin;
    p_op.tag  <= op.tag;
    prod      <= a * b;
  end

  assign res.vld = p_op.vld && p_op.last;
  assign res.fin = p_op.fin;
  assign res.tag = p_op.tag;
  assign res.sum = sum;
endmodule

// ===== hw/rtl/polynomial_term_store_engine_core.sv =====
// Top level of the polynomial term store engine: sequencer around the coefficient RAM.
//
// The block holds NUM_SLOTS polynomials, one 32-bit coefficient per exponent, in a single
// RAM with one write and two read ports. Requests arrive on the req channel and each one
// produces exactly one item on the rsp channel (status, value, term_count).
// One request is worked on at a time; req.ready is high only while the sequencer is idle,
// so the next request can be taken in the cycle after the previous result is loaded.
// Work done from acceptance until the result is loaded into the output register:
//   add or delete a term: one RAM read, then the write back,
//   rejected or trivial requests: no RAM access,
//   evaluate, slot add: one coefficient per cycle through the RAM,
//   clear slot: one zero write per cycle,
//   multiply: a scan of both operands finds their degrees, then every output
//   coefficient is formed by a multiply-accumulate walk over its pairs, one pair per cycle.
// Evaluation uses a running power of x, so each coefficient needs one product per cycle.
// After reset the whole RAM is swept to zero, one word per cycle (RAM_DEPTH = 256 words),
// and req.ready stays low during the sweep.
// The result sits in an output register; when the receiver stalls the block still accepts
// the next request, works it, and holds its result until the output register frees up.
module polynomial_term_store_engine_core (
  input  logic       clk,
  input  logic       rst,
  pts_req_if.sink    req,
  pts_rsp_if.source  rsp
);
  import pts_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_TERM = 4'd2;
  localparam logic [3:0] S_EVAL = 4'd3;
  localparam logic [3:0] S_SUMS = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_CONV = 4'd6;
  localparam logic [3:0] S_RESP = 4'd7;

  logic [3:0]        state;

  // Latched request.
  logic [2:0]        kind_r;
  logic [SLOT_W-1:0] s_r, s2_r, d_r;
  logic [31:0]       coef_r, x_r;
  logic [EXP_W-1:0]  ex_r;

  logic [CNT_W-1:0]  terms [NUM_SLOTS];

  // Clearing sweep.
  logic [ADDR_W-1:0] clr_addr, clr_last;
  logic              clr_item;

  // Read issue counters and the stage that sees the read data.
  logic              iss_on;
  logic [EXP_W-1:0]  ia, ik;
  logic              v1, last1, fin1;
  logic [EXP_W-1:0]  t1;

  logic [31:0]       pw;
  logic [CNT_W-1:0]  cnt_acc;
  logic              any_a, any_b;
  logic [EXP_W-1:0]  max_a, max_b;

  logic [2:0]        res_status;
  logic [31:0]       res_value;
  logic [CNT_W-1:0]  res_count;

  logic              rsp_valid;
  logic [2:0]        rsp_status;
  logic [31:0]       rsp_value;
  logic [CNT_W-1:0]  rsp_count;
  logic              rsp_load;

  // RAM ports.
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]       wdata, q_a, q_b;

  mac_in_t           mac_op;
  mac_out_t          mac_res;

  logic [SLOT_W-1:0] s_n, s2_n, d_n;
  logic [31:0]       term_sum, pair_sum;
  logic              ovf;
  logic [CNT_W-1:0]  conv_cnt, sums_cnt, add_cnt;

  // Decode of an incoming request: where it goes and what it reports if it ends at once.
  logic [3:0]        start_state;
  logic [2:0]        start_status;
  logic [CNT_W-1:0]  start_count;

  assign s_n  = slot_of(req.slot);
  assign s2_n = slot_of(req.second_slot);
  assign d_n  = slot_of(req.dest_slot);

  assign term_sum = q_a + coef_r;
  assign pair_sum = q_a + q_b;
  assign ovf = any_a && any_b &&
               (({1'b0, max_a} + {1'b0, max_b}) > (EXP_W + 1)'(MAX_DEGREE));
  assign sums_cnt = cnt_acc + CNT_W'(pair_sum != 32'd0);
  assign conv_cnt = cnt_acc + CNT_W'(mac_res.sum != 32'd0);
  // Incremental count: a term appears or vanishes at most once per add.
  assign add_cnt = terms[s_r] + CNT_W'((q_a == 32'd0) && (term_sum != 32'd0))
                              - CNT_W'((q_a != 32'd0) && (term_sum == 32'd0));

  // The output register loads when a result is ready and the register is free or draining.
  assign rsp_load = (state == S_RESP) && (!rsp_valid || rsp.ready);

  pts_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (q_a),
    .rdata_b (q_b)
  );

  assign mac_op.vld  = v1 && ((state == S_EVAL) || (state == S_CONV));
  assign mac_op.last = last1;
  assign mac_op.fin  = fin1;
  assign mac_op.tag  = t1;

  pts_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .a   (q_a),
    .b   ((state == S_EVAL) ? pw : q_b),
    .res (mac_res)
  );

  always_comb begin
    start_state  = S_RESP;
    start_status = ST_OK;
    start_count  = terms[s_n];
    unique case (req.kind)
      K_ADD_TERM: begin
        if (req.coef != 32'sd0) begin
          if (int'(req.exponent) > MAX_DEGREE) begin
            start_status = ST_OVERFLOW;
          end else begin
            start_state = S_TERM;
          end
        end
      end
      K_DEL_TERM: begin
        if (terms[s_n] == '0) begin
          start_status = ST_EMPTY;
        end else if (int'(req.exponent) > MAX_DEGREE) begin
          start_status = ST_OVERFLOW;
        end else begin
          start_state = S_TERM;
        end
      end
      K_EVALUATE: begin
        if (terms[s_n] == '0) begin
          start_status = ST_EMPTY;
        end else begin
          start_state = S_EVAL;
        end
      end
      K_ADD_SLOTS: begin
        start_state = S_SUMS;
      end
      K_MUL_SLOTS: begin
        start_count = terms[d_n];
        if ((d_n == s_n) || (d_n == s2_n)) begin
          start_status = ST_ALIAS;
        end else begin
          start_state = S_SCAN;
        end
      end
      K_CLEAR: begin
        start_state = S_CLR;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    raddr_a = mk_addr(s_n, EXP_W'(req.exponent));
    raddr_b = '0;
    we      = 1'b0;
    waddr   = clr_addr;
    wdata   = '0;
    unique case (state)
      S_CLR: begin
        we = 1'b1;
      end
      S_TERM: begin
        waddr = mk_addr(s_r, ex_r);
        if (kind_r == K_ADD_TERM) begin
          we    = 1'b1;
          wdata = term_sum;
        end else begin
          we = (q_a != 32'd0);
        end
      end
      S_EVAL, S_SCAN: begin
        raddr_a = mk_addr(s_r, ia);
        raddr_b = mk_addr(s2_r, ia);
      end
      S_SUMS: begin
        raddr_a = mk_addr(s_r, ia);
        raddr_b = mk_addr(s2_r, ia);
        we      = v1;
        waddr   = mk_addr(d_r, t1);
        wdata   = pair_sum;
      end
      S_CONV: begin
        raddr_a = mk_addr(s_r, ia);
        raddr_b = mk_addr(s2_r, EXP_W'(ik - ia));
        we      = mac_res.vld;
        waddr   = mk_addr(d_r, mac_res.tag);
        wdata   = mac_res.sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      clr_last  <= ADDR_W'(RAM_DEPTH - 1);
      clr_item  <= 1'b0;
      iss_on    <= 1'b0;
      v1        <= 1'b0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        terms[i] <= '0;
      end
    end else begin
      v1 <= iss_on;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      // Read issue: a linear walk, or the pair walk i = 0..k for each output exponent k.
      if (iss_on) begin
        if (state == S_CONV) begin
          last1 <= (ia == ik);
          fin1  <= (ia == ik) && (ik == EXP_W'(TERMS - 1));
          t1    <= ik;
          if (ia == ik) begin
            ia <= '0;
            ik <= ik + 1'b1;
            if (ik == EXP_W'(TERMS - 1)) begin
              iss_on <= 1'b0;
            end
          end else begin
            ia <= ia + 1'b1;
          end
        end else begin
          last1 <= (ia == EXP_W'(TERMS - 1));
          fin1  <= (ia == EXP_W'(TERMS - 1));
          t1    <= ia;
          ia    <= ia + 1'b1;
          if (ia == EXP_W'(TERMS - 1)) begin
            iss_on <= 1'b0;
          end
        end
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_r     <= req.kind;
            s_r        <= s_n;
            s2_r       <= s2_n;
            d_r        <= d_n;
            coef_r     <= req.coef;
            ex_r       <= EXP_W'(req.exponent);
            x_r        <= req.x_value;
            res_value  <= '0;
            res_status <= start_status;
            res_count  <= start_count;
            state      <= start_state;
            // Walk bookkeeping starts fresh; only the walking states use it.
            ia      <= '0;
            pw      <= 32'd1;
            cnt_acc <= '0;
            any_a   <= 1'b0;
            any_b   <= 1'b0;
            max_a   <= '0;
            max_b   <= '0;
            iss_on  <= (start_state == S_EVAL) || (start_state == S_SUMS) ||
                       (start_state == S_SCAN);
            if (start_state == S_CLR) begin
              clr_addr <= mk_addr(s_n, '0);
              clr_last <= mk_addr(s_n, EXP_W'(TERMS - 1));
              clr_item <= 1'b1;
            end
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == clr_last) begin
            if (clr_item) begin
              terms[s_r] <= '0;
              res_status <= ST_OK;
              res_count  <= '0;
              state      <= S_RESP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_TERM: begin
          if (kind_r == K_ADD_TERM) begin
            terms[s_r] <= add_cnt;
            res_count  <= add_cnt;
          end else if (q_a == 32'd0) begin
            res_status <= ST_ABSENT;
          end else begin
            terms[s_r] <= terms[s_r] - 1'b1;
            res_count  <= terms[s_r] - 1'b1;
          end
          state <= S_RESP;
        end
        S_EVAL: begin
          if (v1) begin
            pw <= pw * x_r;
          end
          if (mac_res.vld) begin
            res_value <= mac_res.sum;
            state     <= S_RESP;
          end
        end
        S_SUMS: begin
          if (v1) begin
            cnt_acc <= sums_cnt;
            if (last1) begin
              terms[d_r] <= sums_cnt;
              res_count  <= sums_cnt;
              state      <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (v1) begin
            if (q_a != 32'd0) begin
              any_a <= 1'b1;
              max_a <= t1;
            end
            if (q_b != 32'd0) begin
              any_b <= 1'b1;
              max_b <= t1;
            end
            if (last1) begin
              ia      <= '0;
              ik      <= '0;
              iss_on  <= 1'b1;
              cnt_acc <= '0;
              state   <= S_CONV;
            end
          end
        end
        S_CONV: begin
          if (mac_res.vld) begin
            cnt_acc <= conv_cnt;
            if (mac_res.fin) begin
              terms[d_r] <= conv_cnt;
              res_count  <= conv_cnt;
              res_status <= ovf ? ST_OVERFLOW : ST_OK;
              state      <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (rsp_load) begin
            rsp_status <= res_status;
            rsp_value  <= res_value;
            rsp_count  <= res_count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.value      = rsp_value;
  assign rsp.term_count = 7'(rsp_count);

  // A product write never lands in either operand slot.
  a_conv_dst: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && we) |->
      (waddr[ADDR_W-1:EXP_W] != s_r && waddr[ADDR_W-1:EXP_W] != s2_r))
    else $error("product write hits an operand slot");

  // Only one request is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request accepted while one is in work");

  // The accumulator only closes a sum during evaluation or multiplication.
  a_mac_use: assert property (@(posedge clk) disable iff (rst)
    mac_res.vld |-> (state == S_EVAL || state == S_CONV))
    else $error("accumulator result outside evaluate or multiply");

  // Reads are issued only by the walking states.
  a_issue: assert property (@(posedge clk) disable iff (rst)
    iss_on |-> (state == S_EVAL || state == S_SUMS || state == S_SCAN || state == S_CONV))
    else $error("read issue active in a non-walking state");

endmodule

// ===== tb/polynomial_term_store_engine_core_test.sv =====
// Self-checking test of the polynomial term store engine: directed table, then random items.
`timescale 1ns / 100ps

module polynomial_term_store_engine_core_test;
  import pts_pkg::*;

  logic clk;
  logic rst;

  pts_req_if req ();
  pts_rsp_if rsp ();

  polynomial_term_store_engine_core uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // One request item as it goes on the request channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  slot;
    logic [1:0]  second_slot;
    logic [1:0]  dest_slot;
    logic [31:0] coef;
    logic [5:0]  exponent;
    logic [31:0] x_value;
  } request_t;

  // One result item; "known" marks a directed row whose answer is typed into the table.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [6:0]  term_count;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     known;
    result_t  res;
  } table_row_t;

  // Private copy of the polynomial store that the predictor keeps up to date.
  logic [31:0] poly_coef [NUM_SLOTS][TERMS];
  logic [6:0]  poly_terms [NUM_SLOTS];

  result_t  expected_results [$];
  request_t pending_requests [$];

  int  mismatch_count;
  bit  stimulus_done;
  bit  long_hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous fixed limit: even if every item were a multiply with the
  // longest stalls on both sides, a correct run stays well under a quarter of this.
  initial begin
    #100_000_000;
    $display("[polynomial_term_store_engine_core] ERROR");
    $finish;
  end

  function automatic logic [6:0] count_nonzero(input logic [1:0] s);
    logic [6:0] n;
    n = '0;
    for (int e = 0; e < TERMS; e++) begin
      if (poly_coef[s][e] != 32'd0) n++;
    end
    return n;
  endfunction

  // Apply one request to the private store and return the result it must give.
  function automatic result_t apply_request(input request_t r);
    result_t     o;
    logic [1:0]  s, s2, d, shown;
    logic [31:0] acc, pw, a, b;
    logic [31:0] work [TERMS];
    s  = r.slot % NUM_SLOTS;
    s2 = r.second_slot % NUM_SLOTS;
    d  = r.dest_slot % NUM_SLOTS;
    shown = s;
    o = '0;
    case (r.kind)
      K_ADD_TERM: begin
        if (r.coef != 32'd0) begin
          if (int'(r.exponent) > MAX_DEGREE) begin
            o.status = ST_OVERFLOW;
          end else begin
            poly_coef[s][r.exponent] = poly_coef[s][r.exponent] + r.coef;
            poly_terms[s] = count_nonzero(s);
          end
        end
      end
      K_DEL_TERM: begin
        if (poly_terms[s] == 0) begin
          o.status = ST_EMPTY;
        end else if (int'(r.exponent) > MAX_DEGREE) begin
          o.status = ST_OVERFLOW;
        end else if (poly_coef[s][r.exponent] == 32'd0) begin
          o.status = ST_ABSENT;
        end else begin
          poly_coef[s][r.exponent] = '0;
          poly_terms[s] = count_nonzero(s);
        end
      end
      K_EVALUATE: begin
        if (poly_terms[s] == 0) begin
          o.status = ST_EMPTY;
        end else begin
          acc = '0;
          pw  = 32'd1;
          for (int e = 0; e < TERMS; e++) begin
            acc = acc + poly_coef[s][e] * pw;
            pw  = pw * r.x_value;
          end
          o.value = acc;
        end
      end
      K_ADD_SLOTS: begin
        for (int e = 0; e < TERMS; e++) work[e] = poly_coef[s][e] + poly_coef[s2][e];
        for (int e = 0; e < TERMS; e++) poly_coef[d][e] = work[e];
        poly_terms[d] = count_nonzero(d);
        shown = d;
      end
      K_MUL_SLOTS: begin
        shown = d;
        if (d == s || d == s2) begin
          o.status = ST_ALIAS;
        end else begin
          for (int e = 0; e < TERMS; e++) work[e] = '0;
          for (int i = 0; i < TERMS; i++) begin
            a = poly_coef[s][i];
            if (a != 32'd0) begin
              for (int j = 0; j < TERMS; j++) begin
                b = poly_coef[s2][j];
                if (b != 32'd0) begin
                  if (i + j > MAX_DEGREE) o.status = ST_OVERFLOW;
                  else work[i + j] = work[i + j] + a * b;
                end
              end
            end
          end
          for (int e = 0; e < TERMS; e++) poly_coef[d][e] = work[e];
          poly_terms[d] = count_nonzero(d);
        end
      end
      K_CLEAR: begin
        for (int e = 0; e < TERMS; e++) poly_coef[s][e] = '0;
        poly_terms[s] = '0;
      end
      default: begin
      end
    endcase
    o.term_count = poly_terms[shown];
    return o;
  endfunction

  function automatic request_t make_request(input logic [2:0] k, input logic [1:0] s,
                                            input logic [1:0] s2, input logic [1:0] d,
                                            input logic [31:0] c, input logic [5:0] e,
                                            input logic [31:0] x);
    request_t r;
    r.kind = k; r.slot = s; r.second_slot = s2; r.dest_slot = d;
    r.coef = c; r.exponent = e; r.x_value = x;
    return r;
  endfunction

  function automatic result_t make_result(input logic [2:0] st, input logic [31:0] v,
                                          input logic [6:0] n);
    result_t o;
    o.status = st; o.value = v; o.term_count = n;
    return o;
  endfunction

  // Directed table. Rows with a typed answer cover reset state, extremes and error codes;
  // the rest are checked against the predictor only.
  table_row_t directed [$];

  task automatic add_row(input request_t r, input logic known, input result_t o);
    table_row_t row;
    row.req = r; row.known = known; row.res = o;
    directed.push_back(row);
  endtask

  function automatic logic [2:0] random_kind();
    int p;
    p = $urandom_range(99);
    if (p < 45) return K_ADD_TERM;
    if (p < 57) return K_DEL_TERM;
    if (p < 72) return K_EVALUATE;
    if (p < 82) return K_ADD_SLOTS;
    if (p < 87) return K_MUL_SLOTS;
    if (p < 94) return K_CLEAR;
    return 3'($urandom_range(7));
  endfunction

  // Coefficients mostly small so that sums cancel often, sometimes extreme or fully random.
  function automatic logic [31:0] random_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(6)) - 3);
    endcase
  endfunction

  // Low exponents keep products mostly within degree; a few reach the top.
  function automatic logic [5:0] random_exponent();
    if ($urandom_range(9) == 0) return 6'($urandom_range(63));
    return 6'($urandom_range(7));
  endfunction

  // Valid stays up after an accepted item when the next one follows with no gap; the
  // block drops ready right after an accept, so the old item is never taken twice.
  task automatic send_item(input request_t r);
    int gap;
    gap = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.kind        <= r.kind;
    req.slot        <= r.slot;
    req.second_slot <= r.second_slot;
    req.dest_slot   <= r.dest_slot;
    req.coef        <= r.coef;
    req.exponent    <= r.exponent;
    req.x_value     <= r.x_value;
    do @(posedge clk); while (!req.ready);
    pending_requests.push_back(r);
    expected_results.push_back(apply_request(r));
  endtask

  // Sender: directed rows, then random items with a full-drain pause and a long
  // receiver hold-off in the middle.
  initial begin
    request_t r;
    result_t  o;
    int       items;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      poly_terms[i] = '0;
      for (int e = 0; e < TERMS; e++) poly_coef[i][e] = '0;
    end
    mismatch_count    = 0;
    stimulus_done     = 1'b0;
    long_hold_request = 1'b0;
    rst = 1'b1;
    req.valid <= 1'b0;
    req.kind <= '0; req.slot <= '0; req.second_slot <= '0; req.dest_slot <= '0;
    req.coef <= '0; req.exponent <= '0; req.x_value <= '0;

    // Fresh store: empty slot errors, a zero-coefficient add and aliased products.
    add_row(make_request(K_EVALUATE, 2'd0, 2'd0, 2'd0, 32'd0, 6'd0, 32'd5), 1,
            make_result(ST_EMPTY, 32'd0, 7'd0));
    add_row(make_request(K_DEL_TERM, 2'd3, 2'd0, 2'd0, 32'd0, 6'd63, 32'd0), 1,
            make_result(ST_EMPTY, 32'd0, 7'd0));
    add_row(make_request(K_ADD_TERM, 2'd1, 2'd0, 2'd0, 32'd0, 6'd4, 32'd0), 1,
            make_result(ST_OK, 32'd0, 7'd0));
    add_row(make_request(K_MUL_SLOTS, 2'd0, 2'd1, 2'd1, 32'd0, 6'd0, 32'd0), 1,
            make_result(ST_ALIAS, 32'd0, 7'd0));
    add_row(make_request(K_MUL_SLOTS, 2'd2, 2'd2, 2'd2, 32'd0, 6'd0, 32'd0), 1,
            make_result(ST_ALIAS, 32'd0, 7'd0));
    // Extreme coefficients at the extreme exponents.
    add_row(make_request(K_ADD_TERM, 2'd0, 2'd0, 2'd0, 32'h7FFF_FFFF, 6'd0, 32'd0), 1,
            make_result(ST_OK, 32'd0, 7'd1));
    add_row(make_request(K_ADD_TERM, 2'd0, 2'd0, 2'd0, 32'h8000_0000, 6'd63, 32'd0), 1,
            make_result(ST_OK, 32'd0, 7'd2));
    add_row(make_request(K_EVALUATE, 2'd0, 2'd0, 2'd0, 32'd0, 6'd0, 32'd0), 1,
            make_result(ST_OK, 32'h7FFF_FFFF, 7'd2));
    add_row(make_request(K_EVALUATE, 2'd0, 2'd0, 2'd0, 32'd0, 6'd0, 32'hFFFF_FFFF), 0, '0);
    add_row(make_request(K_EVALUATE, 2'd0, 2'd0, 2'd0, 32'd0, 6'd0, 32'h7FFF_FFFF), 0, '0);
    add_row(make_request(K_DEL_TERM, 2'd0, 2'd0, 2'd0, 32'd0, 6'd5, 32'd0), 1,
            make_result(ST_ABSENT, 32'd0, 7'd2));
    // A sum of zero removes the term.
    add_row(make_request(K_ADD_TERM, 2'd0, 2'd0, 2'd0, 32'h8000_0001, 6'd0, 32'd0), 1,
            make_result(ST_OK, 32'd0, 7'd1));
    add_row(make_request(K_ADD_TERM, 2'd1, 2'd0, 2'd0, 32'd3, 6'd1, 32'd0), 0, '0);
    add_row(make_request(K_ADD_TERM, 2'd1, 2'd0, 2'd0, 32'hFFFF_FFFE, 6'd2, 32'd0), 0, '0);
    // Product whose degree overflows drops the top terms.
    add_row(make_request(K_MUL_SLOTS, 2'd0, 2'd1, 2'd2, 32'd0, 6'd0, 32'd0), 1,
            make_result(ST_OVERFLOW, 32'd0, 7'd0));
    add_row(make_request(K_MUL_SLOTS, 2'd1, 2'd1, 2'd3, 32'd0, 6'd0, 32'd0), 0, '0);
    add_row(make_request(K_EVALUATE, 2'd3, 2'd0, 2'd0, 32'd0, 6'd0, 32'd2), 0, '0);
    // Slot add with the destination equal to a source.
    add_row(make_request(K_ADD_SLOTS, 2'd0, 2'd1, 2'd1, 32'd0, 6'd0, 32'd0), 0, '0);
    add_row(make_request(K_ADD_SLOTS, 2'd3, 2'd3, 2'd3, 32'd0, 6'd0, 32'd0), 0, '0);
    add_row(make_request(K_DEL_TERM, 2'd1, 2'd0, 2'd0, 32'd0, 6'd63, 32'd0), 0, '0);
    // Unused kinds leave the store alone.
    add_row(make_request(3'd6, 2'd1, 2'd2, 2'd3, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF), 0, '0);
    add_row(make_request(3'd7, 2'd2, 2'd3, 2'd0, 32'd1, 6'd1, 32'd1), 0, '0);
    add_row(make_request(K_CLEAR, 2'd3, 2'd0, 2'd0, 32'd0, 6'd0, 32'd0), 1,
            make_result(ST_OK, 32'd0, 7'd0));
    add_row(make_request(K_EVALUATE, 2'd3, 2'd0, 2'd0, 32'd0, 6'd0, 32'd9), 1,
            make_result(ST_EMPTY, 32'd0, 7'd0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_item(directed[i].req);
      if (directed[i].known && expected_results[$] != directed[i].res) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("table row %0d: typed %h, predicted %h", i, directed[i].res,
                   expected_results[$]);
      end
    end

    items = 0;
    while (items < 1700) begin
      if (items == 400) begin
        // Pause until the block has returned every result.
        req.valid <= 1'b0;
        wait (expected_results.size() == 0);
      end
      if (items == 800) long_hold_request = 1'b1;
      r.kind        = random_kind();
      r.slot        = 2'($urandom);
      r.second_slot = 2'($urandom);
      r.dest_slot   = 2'($urandom);
      r.coef        = random_coef();
      r.exponent    = random_exponent();
      r.x_value     = $urandom_range(2) == 0 ? $urandom : 32'($signed($urandom_range(6)) - 3);
      send_item(r);
      items++;
    end
    req.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off so the output register and then
  // the request side back up while the sender keeps offering.
  initial begin
    int stall;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        rsp.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      stall = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(3);
      if ($urandom_range(2) == 0) stall = 0;
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d value %h count %0d",
                   rsp.status, rsp.value, rsp.term_count);
      end else begin
        exp_res = expected_results.pop_front();
        void'(pending_requests.pop_front());
        if (rsp.status !== exp_res.status || rsp.value !== exp_res.value ||
            rsp.term_count !== exp_res.term_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d value %h count %0d, got %0d %h %0d",
                     exp_res.status, exp_res.value, exp_res.term_count,
                     rsp.status, rsp.value, rsp.term_count);
        end
      end
    end
  end

  // End of run: drain, then keep watching for stray results before the verdict.
  initial begin
    wait (stimulus_done);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[polynomial_term_store_engine_core] OK");
    end else begin
      $display("[polynomial_term_store_engine_core] ERROR");
    end
    $finish;
  end

endmodule
